@@ hw/rtl/btm_pkg.sv @@
// ----------------------------------------------------------------------------
// btm_pkg
// Shared types and constants of the binary template matcher.
// ----------------------------------------------------------------------------
package btm_pkg;

  localparam int unsigned PAT_BITS_W = 64;   // pattern register width
  localparam int unsigned PAT_ROW_W  = 8;    // one pattern row per byte
  localparam int unsigned PSIZE_W    = 4;    // pattern width/height registers
  localparam int unsigned ISIZE_W    = 11;   // image width/height registers
  localparam int unsigned COORD_W    = 10;   // match_x / match_y
  localparam int unsigned COUNT_W    = 20;   // match_count
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BITS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd4;

  // register reset values
  localparam logic [PAT_BITS_W-1:0] RST_PATTERN_BITS = '0;
  localparam logic [PSIZE_W-1:0]    RST_PATTERN_SIZE = 4'd8;
  localparam logic [ISIZE_W-1:0]    RST_IMAGE_SIZE   = 11'd1024;

  // control shared by every cell of the window chain
  typedef struct packed {
    logic                  shift;    // a word moves through the window
    logic [PSIZE_W-1:0]    ph;       // effective pattern height, 1..MAX_PATTERN
    logic [PAT_ROW_W-1:0]  rmask;    // low pattern-width bits set
    logic [PAT_BITS_W-1:0] pattern;
  } cell_ctrl_t;

  // pattern size: zero acts as one, oversize acts as the maximum
  function automatic logic [PSIZE_W-1:0] clamp_pat(input logic [PSIZE_W-1:0] v,
                                                   input logic [PSIZE_W-1:0] vmax);
    logic [PSIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = 4'd1;
    end else if (v > vmax) begin
      r = vmax;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/binary_template_matcher.sv @@
// ----------------------------------------------------------------------------
// binary_template_matcher
// Raster-scan binary template matcher with line store and cell chain window.
// ----------------------------------------------------------------------------
// Takes one 1-bit pixel word per clock in raster order and reports every
// pattern_height x pattern_width placement, anywhere in the image, whose
// pixels all equal the configured pattern. Throughput is one pixel per
// cycle while the sink keeps up; a result passes from stage A into the
// output register when the word there moves on. At the accepting edge
// the column's history is read from the line store (registered read, one
// entry per image column, one read and one write port) into stage A; as
// the word leaves stage A its column is shifted into the window cells,
// every row is compared in parallel and the column is written back. A
// result register decouples the output so a stalled sink only holds the
// input once a second word is waiting. Counters and the match count
// return to zero after the last pixel of each frame.
// Configuration is to be written only while the block is idle.
// ----------------------------------------------------------------------------
module binary_template_matcher #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 1024,
  parameter int unsigned MAX_PATTERN = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [btm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [btm_pkg::PAT_BITS_W-1:0]     cfg_data_i,
  // pixel stream
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               pixel_i,
  // match results
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [btm_pkg::COORD_W-1:0]        match_x_o,
  output logic [btm_pkg::COORD_W-1:0]        match_y_o,
  output logic [btm_pkg::COUNT_W-1:0]        match_count_o
);
  import btm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);   // column counter
  localparam int unsigned RW = $clog2(MAX_HEIGHT);  // row counter
  localparam int unsigned P  = MAX_PATTERN;
  // wide enough for a counter plus one and for a coordinate
  localparam int unsigned XW = (CW + 1 > COORD_W) ? CW + 1 : COORD_W;
  localparam int unsigned YW = (RW + 1 > COORD_W) ? RW + 1 : COORD_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [PAT_BITS_W-1:0] pattern_q;
  logic [PSIZE_W-1:0]    pat_w_q, pat_h_q;
  logic [ISIZE_W-1:0]    img_w_q, img_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= RST_PATTERN_BITS;
      pat_w_q   <= RST_PATTERN_SIZE;
      pat_h_q   <= RST_PATTERN_SIZE;
      img_w_q   <= RST_IMAGE_SIZE;
      img_h_q   <= RST_IMAGE_SIZE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PATTERN_BITS:   pattern_q <= cfg_data_i;
        CFG_PATTERN_WIDTH:  pat_w_q   <= cfg_data_i[PSIZE_W-1:0];
        CFG_PATTERN_HEIGHT: pat_h_q   <= cfg_data_i[PSIZE_W-1:0];
        CFG_IMAGE_WIDTH:    img_w_q   <= cfg_data_i[ISIZE_W-1:0];
        CFG_IMAGE_HEIGHT:   img_h_q   <= cfg_data_i[ISIZE_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // effective sizes: out-of-range values fall back to the limits
  logic [PSIZE_W-1:0] pw_eff, ph_eff;
  logic [CW:0]        w_eff;
  logic [RW:0]        h_eff;
  logic [PAT_ROW_W-1:0] rmask;

  assign pw_eff = clamp_pat(pat_w_q, PSIZE_W'(P));
  assign ph_eff = clamp_pat(pat_h_q, PSIZE_W'(P));
  assign w_eff  = ((img_w_q == '0) || (32'(img_w_q) > 32'(MAX_WIDTH)))
                  ? (CW+1)'(MAX_WIDTH) : (CW+1)'(img_w_q);
  assign h_eff  = ((img_h_q == '0) || (32'(img_h_q) > 32'(MAX_HEIGHT)))
                  ? (RW+1)'(MAX_HEIGHT) : (RW+1)'(img_h_q);
  assign rmask  = PAT_ROW_W'((9'd1 << pw_eff) - 9'd1);

  // ---------------------------------------------------------------------
  // Stage A: raster counters and line store read, at accept
  // ---------------------------------------------------------------------
  logic          accept, fire;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          last_col, last_row;
  logic          check;
  logic [XW-1:0] x_full;
  logic [YW-1:0] y_full;

  logic               a_valid_q;
  logic               a_pix_q, a_check_q, a_eof_q;
  logic [CW-1:0]      a_col_q;
  logic [COORD_W-1:0] a_x_q, a_y_q;

  assign in_ready_o = !a_valid_q || fire;
  assign accept     = in_valid_i && in_ready_o;

  assign col_inc  = {1'b0, col_q} + (CW+1)'(1);
  assign row_inc  = {1'b0, row_q} + (RW+1)'(1);
  assign last_col = (col_inc >= w_eff);
  assign last_row = (row_inc >= h_eff);
  assign check    = (col_inc >= (CW+1)'(pw_eff)) && (row_inc >= (RW+1)'(ph_eff));
  assign x_full   = XW'(col_inc) - XW'(pw_eff);
  assign y_full   = YW'(row_inc) - YW'(ph_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_inc[RW-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (fire) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pix_q   <= pixel_i;
      a_check_q <= check;
      a_eof_q   <= last_col && last_row;
      a_col_q   <= col_q;
      a_x_q     <= x_full[COORD_W-1:0];
      a_y_q     <= y_full[COORD_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Line store: bit k of an entry is the pixel k+1 rows above
  // ---------------------------------------------------------------------
  logic [P-2:0] hist;
  logic [P-1:0] col_vec;

  assign fire    = a_valid_q && (!out_valid_o || out_ready_i);
  assign col_vec = {hist, a_pix_q};

  btm_line_store #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (P - 1)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (hist),
    .wr_en_i   (fire),
    .wr_addr_i (a_col_q),
    .wr_data_i (col_vec[P-2:0])
  );

  // ---------------------------------------------------------------------
  // Stage B: window cell chain, one cell per window row
  // ---------------------------------------------------------------------
  cell_ctrl_t cell_ctrl;
  logic [P:0] chain;

  assign cell_ctrl.shift   = fire;
  assign cell_ctrl.ph      = ph_eff;
  assign cell_ctrl.rmask   = rmask;
  assign cell_ctrl.pattern = pattern_q;
  assign chain[0]          = 1'b1;

  for (genvar k = 0; k < P; k++) begin : g_cell
    btm_cell #(
      .P (P),
      .K (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .bit_i   (col_vec[k]),
      .match_i (chain[k]),
      .match_o (chain[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // Match count and result register
  // ---------------------------------------------------------------------
  logic               hit;
  logic [COUNT_W-1:0] count_q, count_inc;
  logic               out_valid_q;
  logic [COORD_W-1:0] out_x_q, out_y_q;
  logic [COUNT_W-1:0] out_count_q;

  assign hit       = a_check_q && chain[P];
  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 20'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        if (a_eof_q) begin
          count_q <= '0;   // new frame starts from zero
        end else if (hit) begin
          count_q <= count_inc;
        end
      end
      if (fire && hit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && hit) begin
      out_x_q     <= a_x_q;
      out_y_q     <= a_y_q;
      out_count_q <= count_inc;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_x_o     = out_x_q;
  assign match_y_o     = out_y_q;
  assign match_count_o = out_count_q;

`ifndef SYNTHESIS
  // input stalls only behind a word that cannot move on
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (a_valid_q && out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked word");

  // a word held in stage A keeps its column
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !fire) |=> (a_valid_q && $stable(a_col_q)))
    else $error("stage A word lost or changed while held");

  // every match leaves a result in the output register
  hit_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && hit) |=> (out_valid_o && (match_count_o != '0)))
    else $error("match did not reach the output register");

  // end of frame clears the match count
  eof_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && a_eof_q) |=> (count_q == '0))
    else $error("match count not cleared at end of frame");
`endif

endmodule

@@ hw/rtl/btm_line_store.sv @@
// ----------------------------------------------------------------------------
// btm_line_store
// Column store of the rows above the current one; registered read with
// write-through when the same column is written in the read cycle.
// ----------------------------------------------------------------------------
module btm_line_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 7
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/btm_cell.sv @@
// ----------------------------------------------------------------------------
// btm_cell
// One window row: shifts in its column bit and checks the row against its
// pattern row, passing the running match on to the next cell.
// ----------------------------------------------------------------------------
module btm_cell #(
  parameter int unsigned P = 8,   // window width
  parameter int unsigned K = 0    // rows above the current row
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  btm_pkg::cell_ctrl_t ctrl_i,
  input  logic                bit_i,
  input  logic                match_i,
  output logic                match_o
);
  import btm_pkg::*;

  logic [P-1:0]       row_q, row_d;
  logic [PSIZE_W-1:0] pat_idx;
  logic               active;
  logic [P-1:0]       want, have;

  assign row_d   = {row_q[P-2:0], bit_i};
  assign active  = (PSIZE_W'(K) < ctrl_i.ph);
  assign pat_idx = ctrl_i.ph - 4'd1 - PSIZE_W'(K);
  assign want    = ctrl_i.pattern[{pat_idx[2:0], 3'b000} +: P] & ctrl_i.rmask[P-1:0];
  assign have    = row_d & ctrl_i.rmask[P-1:0];
  assign match_o = match_i & (!active || (want == have));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (ctrl_i.shift) begin
      row_q <= row_d;
    end
  end

endmodule
